// File: rtl/core/mcg_pkg.sv
package mcg_pkg;

  // Sine table depth and the index width that follows from it.
  localparam int unsigned SINE_TABLE_DEPTH = 256;
  localparam int unsigned SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);

  // Payload and register widths.
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned PERIOD_W    = 32;
  localparam int unsigned BPB_W       = 6;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned LENGTH_W    = 13;
  localparam int unsigned PHASE_W     = 24;
  localparam int unsigned STEP_W      = 23;
  localparam int unsigned ENV_W       = 16;
  localparam int unsigned LEVEL_W     = 15;
  localparam int unsigned SAMPLE_W    = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BEAT_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEATS_PER_BAR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_LENGTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCENT_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_LEVEL   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_ENABLE  = 3'd7;

  // Beat position step per sample: one sample in 1/4096 units.
  localparam logic [PERIOD_W:0] ONE_SAMPLE = 33'd4096;

  // Accent gain 1.4 in Q1.15 with rounding.
  localparam logic [15:0] ACCENT_GAIN = 16'd45875;

  // Odd polynomial coefficients for the quarter-wave sine, Q30.
  localparam logic [63:0] C1 = 64'd1686629713;
  localparam logic [63:0] C3 = 64'd693598669;
  localparam logic [63:0] C5 = 64'd85569306;
  localparam logic [63:0] C7 = 64'd5026995;
  localparam logic [63:0] C9 = 64'd172272;

  typedef struct packed {
    logic beat;
    logic down;
  } beat_info_t;

  typedef logic signed [SAMPLE_W-1:0] sine_tab_t [SINE_TABLE_DEPTH];

  function automatic logic [63:0] mulq30(logic [63:0] a, logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  // Sine of a 24-bit phase, Q1.15, quadrant folded.
  function automatic logic signed [SAMPLE_W-1:0] sine_of_phase(logic [PHASE_W-1:0] p);
    logic [1:0]  q;
    logic [22:0] r;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] v;
    q = p[23:22];
    r = {1'b0, p[21:0]};
    if (q[0]) begin
      r = 23'h400000 - r;
    end
    t   = {41'd0, r} << 8;
    t2  = mulq30(t, t);
    acc = C7 - mulq30(t2, C9);
    acc = C5 - mulq30(t2, acc);
    acc = C3 - mulq30(t2, acc);
    acc = C1 - mulq30(t2, acc);
    s   = mulq30(t, acc);
    v   = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return q[1] ? -v[SAMPLE_W-1:0] : v[SAMPLE_W-1:0];
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] ph;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      ph     = (64'(i) << 24) / SINE_TABLE_DEPTH;
      tab[i] = sine_of_phase(ph[PHASE_W-1:0]);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

// File: rtl/core/mcg_sine_rom.sv
module mcg_sine_rom (
  input  logic                                clk_i,
  input  logic [mcg_pkg::PHASE_W-1:0]         phase_i,
  output logic signed [mcg_pkg::SAMPLE_W-1:0] sine_o
);
  import mcg_pkg::*;

  localparam int unsigned PROD_W = PHASE_W + 14;

  logic [PROD_W-1:0]     idx_prod;
  logic [SINE_IDX_W-1:0] idx;

  // Scale the phase to the table depth and keep the integer part.
  assign idx_prod = PROD_W'(phase_i) * PROD_W'(SINE_TABLE_DEPTH);
  assign idx      = idx_prod[PHASE_W +: SINE_IDX_W];

  always_ff @(posedge clk_i) begin
    sine_o <= SINE_TAB[idx];
  end

endmodule

// File: rtl/core/mcg_beat_tracker.sv
module mcg_beat_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          restart_i,
  input  logic [mcg_pkg::PERIOD_W-1:0]  beat_period_i,
  input  logic [mcg_pkg::BPB_W-1:0]     beats_per_bar_i,
  output mcg_pkg::beat_info_t           info_o
);
  import mcg_pkg::*;

  logic [PERIOD_W-1:0] acc_q, acc_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic                first_q, first_d;

  logic [PERIOD_W-1:0] acc0;
  logic [COUNT_W-1:0]  count0;
  logic                first0;
  logic [PERIOD_W:0]   sum;
  logic [BPB_W-1:0]    bpb;
  logic [BPB_W-1:0]    next_count;

  always_comb begin
    bpb = beats_per_bar_i;
    if (bpb == '0) begin
      bpb = BPB_W'(1);
    end else if (bpb > BPB_W'(32)) begin
      bpb = BPB_W'(32);
    end

    acc0   = restart_i ? '0 : acc_q;
    count0 = restart_i ? '0 : count_q;
    first0 = restart_i | first_q;

    sum        = {1'b0, acc0} + ONE_SAMPLE;
    next_count = {1'b0, count0} + BPB_W'(1);

    acc_d       = acc0;
    count_d     = count0;
    first_d     = 1'b0;
    info_o.beat = 1'b0;

    if (first0) begin
      info_o.beat = 1'b1;
    end else begin
      if (sum >= {1'b0, beat_period_i}) begin
        sum         = sum - {1'b0, beat_period_i};
        count_d     = (next_count >= bpb) ? '0 : next_count[COUNT_W-1:0];
        info_o.beat = 1'b1;
      end
      acc_d = sum[PERIOD_W-1:0];
    end
    info_o.down = info_o.beat && (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      count_q <= '0;
      first_q <= 1'b1;
    end else if (step_i) begin
      acc_q   <= acc_d;
      count_q <= count_d;
      first_q <= first_d;
    end
  end

endmodule

// File: rtl/core/metronome_click_generator.sv
// A sample with a running click goes from transfer to output valid through level, two
// shared-multiplier products, envelope decay and output load (the beat update lands on
// the transfer edge); a silent sample goes straight to output load. One 32x16 multiplier
// does the math; a new sample is taken only once the last reaches the output register.
// Input is taken while a result waits. Reset: beat position, count and click state
// clear, beat zero is armed, registers take defaults (clicks off, 4/4, default tempo).
module metronome_click_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Sample tick input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                restart_i,
  // Click output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mcg_pkg::SAMPLE_W-1:0] click_sample_o,
  output logic                                beat_start_o,
  output logic                                downbeat_start_o,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [mcg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mcg_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import mcg_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for a tick, track the beat
  localparam logic [2:0] S_LVL  = 3'd1;  // accent level via the multiplier
  localparam logic [2:0] S_M1   = 3'd2;  // |sine| * envelope
  localparam logic [2:0] S_M2   = 3'd3;  // * level, round, saturate; advance phase
  localparam logic [2:0] S_M3   = 3'd4;  // envelope * decay
  localparam logic [2:0] S_DONE = 3'd5;  // hand the result to the output register

  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned PROD_W  = 31;

  // Configuration registers.
  logic [PERIOD_W-1:0] beat_period_q;
  logic [BPB_W-1:0]    beats_per_bar_q;
  logic [LENGTH_W-1:0] click_length_q;
  logic [STEP_W-1:0]   accent_step_q;
  logic [STEP_W-1:0]   normal_step_q;
  logic [ENV_W-1:0]    decay_factor_q;
  logic [LEVEL_W-1:0]  click_level_q;
  logic                click_enable_q;

  // Click state.
  logic [2:0]          state_q, state_d;
  logic [LENGTH_W-1:0] remaining_q, remaining_d;
  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic [ENV_W-1:0]    env_q, env_d;
  logic                accent_q, accent_d;

  // Per-sample work registers.
  logic [LEVEL_W-1:0]  lvl_q, lvl_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic                sneg_q, sneg_d;
  logic [SAMPLE_W-1:0] res_sample_q, res_sample_d;
  logic                res_beat_q, res_beat_d;
  logic                res_down_q, res_down_d;

  // Output register.
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_sample_q;
  logic                out_beat_q;
  logic                out_down_q;

  logic                      accept;
  logic                      out_load;
  beat_info_t                binfo;
  logic signed [SAMPLE_W-1:0] sine;
  logic [LEVEL_W-1:0]        sine_mag;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [MUL_P_W-1:0]        mul_p;
  logic [MUL_P_W-1:0]        rnd;
  logic [SAMPLE_W-1:0]       al;
  logic [SAMPLE_W-1:0]       mag;
  logic [STEP_W-1:0]         step;
  logic [LENGTH_W-1:0]       start_remaining;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  mcg_beat_tracker u_beat (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (accept),
    .restart_i      (restart_i),
    .beat_period_i  (beat_period_q),
    .beats_per_bar_i(beats_per_bar_q),
    .info_o         (binfo)
  );

  // Table output is a registered copy of the entry for phase_q; phase holds through S_LVL and S_M1.
  mcg_sine_rom u_rom (
    .clk_i  (clk_i),
    .phase_i(phase_q),
    .sine_o (sine)
  );

  // Magnitude of a table entry: entries stay within +-32767.
  assign sine_mag = sine[SAMPLE_W-1] ? LEVEL_W'(-sine) : sine[LEVEL_W-1:0];

  // Shared multiplier: one product per sequencer step.
  always_comb begin
    unique case (state_q)
      S_LVL: begin
        mul_a = MUL_A_W'(click_level_q);
        mul_b = ACCENT_GAIN;
      end
      S_M1: begin
        mul_a = MUL_A_W'(sine_mag);
        mul_b = env_q;
      end
      S_M2: begin
        mul_a = MUL_A_W'(prod_q);
        mul_b = MUL_B_W'(lvl_q);
      end
      S_M3: begin
        mul_a = MUL_A_W'(env_q);
        mul_b = decay_factor_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  always_comb begin
    state_d      = state_q;
    remaining_d  = remaining_q;
    phase_d      = phase_q;
    env_d        = env_q;
    accent_d     = accent_q;
    lvl_d        = lvl_q;
    prod_d       = prod_q;
    sneg_d       = sneg_q;
    res_sample_d = res_sample_q;
    res_beat_d   = res_beat_q;
    res_down_d   = res_down_q;
    rnd          = '0;
    al           = '0;
    mag          = '0;
    step         = accent_q ? accent_step_q : normal_step_q;
    start_remaining = remaining_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_sample_d = '0;
          if (!click_enable_q) begin
            // Disabled: beats still advance, but cut any click and drop the flags.
            start_remaining = '0;
            res_beat_d      = 1'b0;
            res_down_d      = 1'b0;
          end else begin
            res_beat_d = binfo.beat;
            res_down_d = binfo.down;
            if (binfo.beat) begin
              // A new beat replaces whatever click is running.
              start_remaining = click_length_q;
              phase_d         = '0;
              env_d           = {ENV_W{1'b1}};
              accent_d        = binfo.down;
            end
          end
          remaining_d = start_remaining;
          state_d     = (start_remaining != '0) ? S_LVL : S_DONE;
        end
      end
      S_LVL: begin
        al    = SAMPLE_W'((MUL_P_W'(mul_p[30:0]) + MUL_P_W'(16384)) >> 15);
        lvl_d = click_level_q;
        if (accent_q) begin
          lvl_d = al[SAMPLE_W-1] ? {LEVEL_W{1'b1}} : al[LEVEL_W-1:0];
        end
        state_d = S_M1;
      end
      S_M1: begin
        prod_d  = mul_p[PROD_W-1:0];
        sneg_d  = sine[SAMPLE_W-1];
        state_d = S_M2;
      end
      S_M2: begin
        rnd = mul_p + (MUL_P_W'(1) << 30);
        mag = rnd[31 +: SAMPLE_W];
        if (mag[SAMPLE_W-1]) begin
          mag = SAMPLE_W'(32767);
        end
        res_sample_d = sneg_q ? -mag : mag;
        phase_d      = phase_q + PHASE_W'(step);
        remaining_d  = remaining_q - LENGTH_W'(1);
        state_d      = S_M3;
      end
      S_M3: begin
        env_d   = mul_p[ENV_W +: ENV_W];
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and click state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      remaining_q <= '0;
      phase_q     <= '0;
      env_q       <= '0;
      accent_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      remaining_q <= remaining_d;
      phase_q     <= phase_d;
      env_q       <= env_d;
      accent_q    <= accent_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Work and output payload.
  always_ff @(posedge clk_i) begin
    lvl_q        <= lvl_d;
    prod_q       <= prod_d;
    sneg_q       <= sneg_d;
    res_sample_q <= res_sample_d;
    res_beat_q   <= res_beat_d;
    res_down_q   <= res_down_d;
    if (out_load) begin
      out_sample_q <= res_sample_q;
      out_beat_q   <= res_beat_q;
      out_down_q   <= res_down_q;
    end
  end

  // Configuration writes: the user must write only while idle; the block does not check.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_period_q   <= 32'd98304000;
      beats_per_bar_q <= 6'd4;
      click_length_q  <= 13'd1440;
      accent_step_q   <= 23'd524288;
      normal_step_q   <= 23'd349525;
      decay_factor_q  <= 16'd65384;
      click_level_q   <= 15'd11469;
      click_enable_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BEAT_PERIOD:   beat_period_q   <= cfg_data_i[PERIOD_W-1:0];
        REG_BEATS_PER_BAR: beats_per_bar_q <= cfg_data_i[BPB_W-1:0];
        REG_CLICK_LENGTH:  click_length_q  <= cfg_data_i[LENGTH_W-1:0];
        REG_ACCENT_STEP:   accent_step_q   <= cfg_data_i[STEP_W-1:0];
        REG_NORMAL_STEP:   normal_step_q   <= cfg_data_i[STEP_W-1:0];
        REG_DECAY_FACTOR:  decay_factor_q  <= cfg_data_i[ENV_W-1:0];
        REG_CLICK_LEVEL:   click_level_q   <= cfg_data_i[LEVEL_W-1:0];
        REG_CLICK_ENABLE:  click_enable_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign click_sample_o   = out_sample_q;
  assign beat_start_o     = out_beat_q;
  assign downbeat_start_o = out_down_q;

endmodule
